>>> rtl/rcf_pkg.sv
package rcf_pkg;

    // lane and source counts
    localparam int LANES = 7;
    localparam int NSRC  = 7;

    // selector code meaning no source, or all lanes for a set press
    localparam logic [2:0] NONE_SEL = 3'd7;

    // fade fraction constants, Q1.16
    localparam logic [16:0] UNITY     = 17'd65536;
    localparam logic [16:0] LOW_EDGE  = 17'd6;
    localparam logic [16:0] HIGH_EDGE = 17'd65530;

    // field layout of the input request data
    localparam int SAMPLE_W = 16;
    localparam int TGT_LSB  = 0;
    localparam int LANE_LSB = 3;
    localparam int CV_LSB   = 6;
    localparam int SRC_LSB  = 22;
    localparam int SRCS_W   = NSRC * SAMPLE_W;
    localparam int IN_W     = 136;
    localparam int OUT_W    = 40;
    localparam int GAINS_W  = NSRC * 8;

    // reciprocal of five, 2^20/5 rounded down, one correction step after it
    localparam logic [17:0] RECIP_5  = 18'd209715;
    localparam int          RECIP_SH = 20;

    // mixer accumulator
    localparam int                        ACC_W     = 60;
    localparam logic signed [ACC_W-1:0] MIX_ROUND = 60'sh00_0080_0000_0000;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_SAMPLE,
        OP_SELECT,
        OP_SET_TOP,
        OP_SET_BOT
    } t_op;

    typedef enum logic [1:0] {
        REG_RANGE,
        REG_SWITCH,
        REG_GGAIN,
        REG_SGAINS
    } t_reg;

    typedef enum logic [1:0] {
        RANGE_UNI5,
        RANGE_BI5,
        RANGE_UNI10,
        RANGE_BI10
    } t_range;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SCALE,
        F_COMMIT,
        F_PICK,
        F_PUSH
    } t_fstate;

    typedef enum logic [1:0] {
        B_IDLE,
        B_PART,
        B_SUM,
        B_DONE
    } t_bstate;

    typedef struct packed {
        t_range             cv_range;
        logic               instant_commit;
        logic [16:0]        mix_gain;
        logic [GAINS_W-1:0] source_gains;
    } t_cfg;

    // one classified sample request, ready for mixing
    typedef struct packed {
        logic [2:0]         lane;
        logic [16:0]        fade;
        logic signed [15:0] s_top;
        logic [7:0]         c_top;
        logic signed [15:0] s_bot;
        logic [7:0]         c_bot;
        logic               top_wait;
        logic               bot_wait;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic [2:0]         lane;
        logic signed [15:0] mixed;
        logic [16:0]        fade;
        logic               top_wait;
        logic               bot_wait;
    } t_res;

endpackage

>>> rtl/routed_crossfade_matrix_core.sv
// channel   direction  handshake                  payload
// s         in         i_s_tvalid / o_s_tready    i_s_tdata, i_s_tuser (op)
// m         out        o_m_tvalid / i_m_tready    o_m_tdata, o_m_tuser (waiting flags)
// cfg       in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// button requests are taken one per cycle while the front is idle; a sample request then
// holds the front through scale, divide by five and commit, top pick, and bottom pick and
// queue write, so the front takes no new request until that sample is queued; the back works
// each sample through gain products, split weight products, side sums, round and register.
// synchronous active-low reset sets routes to defaults; no clearing pass.
// a two-entry queue and the output register let either side stall alone.
module routed_crossfade_matrix_core import rcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    // target, lane, fade_cv, source_a .. source_g, zero fill
    input  logic [IN_W-1:0]  i_s_tdata,
    // op
    input  logic [1:0]       i_s_tuser,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    // out_lane, mixed_sample, fade_level, zero fill
    output logic [OUT_W-1:0] o_m_tdata,
    // top_waiting, bottom_waiting
    output logic [1:0]       o_m_tuser,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [55:0]      i_cfg_data
);

    t_cfg   r_cfg;
    t_job   push_job;
    t_job   head_job;
    t_qstat qstat;
    t_res   res;
    logic   push;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cv_range       <= RANGE_UNI5;
            r_cfg.instant_commit <= 1'b0;
            r_cfg.mix_gain       <= UNITY;
            r_cfg.source_gains   <= '1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (t_reg'(i_cfg_index))
                REG_RANGE:  r_cfg.cv_range       <= t_range'(i_cfg_data[1:0]);
                REG_SWITCH: r_cfg.instant_commit <= i_cfg_data[0];
                REG_GGAIN:  r_cfg.mix_gain       <= i_cfg_data[16:0];
                REG_SGAINS: r_cfg.source_gains   <= i_cfg_data[GAINS_W-1:0];
                default:    r_cfg <= r_cfg;
            endcase
        end
    end

    rcf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_op    (i_s_tuser),
        .i_data  (i_s_tdata),
        .o_push  (push),
        .o_job   (push_job),
        .i_qstat (qstat)
    );

    rcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_qstat (qstat)
    );

    rcf_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mix_gain (r_cfg.mix_gain),
        .i_job      (head_job),
        .i_qstat    (qstat),
        .o_pop      (pop),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_res      (res)
    );

    // result packing
    assign o_m_tdata = {4'b0, res.fade, res.mixed, res.lane};
    assign o_m_tuser = {res.bot_wait, res.top_wait};

endmodule

>>> rtl/rcf_front.sv
module rcf_front import rcf_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [1:0]      i_op,
    input  logic [IN_W-1:0] i_data,
    output logic            o_push,
    output t_job            o_job,
    input  t_qstat          i_qstat
);

    t_fstate r_state, n_state;

    logic [2:0] r_cur;
    logic [2:0] r_top   [LANES];
    logic [2:0] r_top_p [LANES];
    logic [2:0] r_bot   [LANES];
    logic [2:0] r_bot_p [LANES];

    logic [2:0]              r_lane;
    logic signed [15:0]      r_cv;
    logic [SRCS_W-1:0]       r_srcs;
    logic                    r_le0;
    logic                    r_ge;
    logic [18:0]             r_v;
    logic [36:0]             r_prod;
    logic [16:0]             r_fade;
    logic [2:0]              r_tsel;
    logic [2:0]              r_bsel;
    logic                    r_twait;
    logic                    r_bwait;
    logic signed [15:0]      r_s_top;
    logic [7:0]              r_c_top;

    t_op        op;
    logic [2:0] target;
    logic [2:0] lane;
    logic       accept;

    assign op     = t_op'(i_op);
    assign target = i_data[TGT_LSB +: 3];
    assign lane   = i_data[LANE_LSB +: 3];
    assign accept = i_valid && o_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept && op == OP_SAMPLE && lane < LANES) n_state = F_SCALE;
            end
            F_SCALE:  n_state = F_COMMIT;
            F_COMMIT: n_state = F_PICK;
            F_PICK:   n_state = F_PUSH;
            F_PUSH: begin
                if (!i_qstat.full) n_state = F_IDLE;
            end
            default:  n_state = F_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        unique case (r_state)
            F_IDLE:  o_ready = 1'b1;
            F_PUSH:  o_push  = !i_qstat.full;
            default: begin
                o_ready = 1'b0;
                o_push  = 1'b0;
            end
        endcase
    end

    // range scaling: offset, span and the shift that takes out the power of two
    logic signed [17:0] off;
    logic signed [17:0] den;
    logic [4:0]         m5;
    logic [1:0]         sh;
    logic signed [17:0] x;
    logic [21:0]        num;

    always_comb begin
        unique case (i_cfg.cv_range)
            RANGE_UNI5:  begin off = 18'sd0;     den = 18'sd10240; m5 = 5'd5;  sh = 2'd1; end
            RANGE_BI5:   begin off = 18'sd10240; den = 18'sd20480; m5 = 5'd10; sh = 2'd2; end
            RANGE_UNI10: begin off = 18'sd0;     den = 18'sd20480; m5 = 5'd10; sh = 2'd2; end
            RANGE_BI10:  begin off = 18'sd20480; den = 18'sd40960; m5 = 5'd20; sh = 2'd3; end
            default:     begin off = 18'sd0;     den = 18'sd10240; m5 = 5'd5;  sh = 2'd1; end
        endcase
        x   = 18'(r_cv) + off;
        num = {x[15:0], 6'b0} + 22'(m5);
    end

    // quotient by five: reciprocal estimate, then one correction
    logic [16:0] q0;
    logic [19:0] rem;
    logic [16:0] q;
    logic [16:0] fade;

    always_comb begin
        q0   = r_prod[RECIP_SH +: 17];
        rem  = {1'b0, r_v} - 20'(q0) * 20'd5;
        q    = (rem >= 20'd5) ? q0 + 17'd1 : q0;
        if (r_le0)     fade = 17'd0;
        else if (r_ge) fade = UNITY;
        else           fade = q;
    end

    // route commit for the lane under way
    logic       commit_t;
    logic       commit_b;
    logic [2:0] new_t;
    logic [2:0] new_b;

    always_comb begin
        commit_t = i_cfg.instant_commit || (fade <= LOW_EDGE);
        commit_b = i_cfg.instant_commit || (fade >= HIGH_EDGE);
        new_t    = commit_t ? r_top_p[r_lane] : r_top[r_lane];
        new_b    = commit_b ? r_bot_p[r_lane] : r_bot[r_lane];
    end

    // shared source selector: top in the pick step, bottom in the push step
    logic [2:0]         sel;
    logic signed [15:0] pick_s;
    logic [7:0]         pick_c;

    always_comb begin
        sel = (r_state == F_PUSH) ? r_bsel : r_tsel;
        if (sel < NSRC) begin
            pick_s = r_srcs[sel*SAMPLE_W +: SAMPLE_W];
            pick_c = i_cfg.source_gains[sel*8 +: 8];
        end else begin
            pick_s = 16'sd0;
            pick_c = 8'd0;
        end
    end

    // state and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_cur   <= NONE_SEL;
            for (int l = 0; l < LANES; l++) begin
                r_top[l]   <= 3'(l);
                r_top_p[l] <= 3'(l);
                r_bot[l]   <= NONE_SEL;
                r_bot_p[l] <= NONE_SEL;
            end
        end else begin
            r_state <= n_state;
            if (accept) begin
                unique case (op)
                    OP_SELECT: r_cur <= target;
                    OP_SET_TOP: begin
                        for (int l = 0; l < LANES; l++) begin
                            if (target == NONE_SEL || target == 3'(l)) begin
                                if (r_top_p[l] == r_cur) r_top[l] <= r_cur;
                                r_top_p[l] <= r_cur;
                            end
                        end
                    end
                    OP_SET_BOT: begin
                        for (int l = 0; l < LANES; l++) begin
                            if (target == NONE_SEL || target == 3'(l)) begin
                                if (r_bot_p[l] == r_cur) r_bot[l] <= r_cur;
                                r_bot_p[l] <= r_cur;
                            end
                        end
                    end
                    OP_SAMPLE: begin
                        r_lane <= lane;
                        r_cv   <= i_data[CV_LSB +: SAMPLE_W];
                        r_srcs <= i_data[SRC_LSB +: SRCS_W];
                    end
                    default: r_cur <= r_cur;
                endcase
            end
            if (r_state == F_SCALE) begin
                r_le0  <= x[17] || (x == 18'sd0);
                r_ge   <= (x >= den);
                r_v    <= 19'(num >> sh);
                r_prod <= 19'(num >> sh) * RECIP_5;
            end
            if (r_state == F_COMMIT) begin
                r_fade         <= fade;
                r_top[r_lane]  <= new_t;
                r_bot[r_lane]  <= new_b;
                r_tsel         <= new_t;
                r_bsel         <= new_b;
                r_twait        <= (new_t != r_top_p[r_lane]);
                r_bwait        <= (new_b != r_bot_p[r_lane]);
            end
            if (r_state == F_PICK) begin
                r_s_top <= pick_s;
                r_c_top <= pick_c;
            end
        end
    end

    // request for the back end
    always_comb begin
        o_job.lane     = r_lane;
        o_job.fade     = r_fade;
        o_job.s_top    = r_s_top;
        o_job.c_top    = r_c_top;
        o_job.s_bot    = pick_s;
        o_job.c_bot    = pick_c;
        o_job.top_wait = r_twait;
        o_job.bot_wait = r_bwait;
    end

endmodule

>>> rtl/rcf_queue.sv
module rcf_queue import rcf_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_job   i_job,
    input  logic   i_pop,
    output t_job   o_job,
    output t_qstat o_qstat
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_AW:0]   r_count;

    assign o_job         = r_mem[r_rp];
    assign o_qstat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp <= (r_wp == Q_AW'(Q_DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            if (i_push && !i_pop)      r_count <= r_count + 1'b1;
            else if (i_pop && !i_push) r_count <= r_count - 1'b1;
        end
    end

    // front never writes a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_qstat.full)
        else $error("queue written while full");

    // back never reads an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_qstat.empty)
        else $error("queue read while empty");

    // a lone write raises the level by one
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue level not raised by a write");

    // level stays within depth
    a_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (Q_AW+1)'(Q_DEPTH))
        else $error("queue level beyond depth");

endmodule

>>> rtl/rcf_back.sv
module rcf_back import rcf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [16:0] i_mix_gain,
    input  t_job        i_job,
    input  t_qstat      i_qstat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output t_res        o_res
);

    t_bstate r_state, n_state;

    logic [2:0]              r_lane;
    logic [16:0]             r_fade;
    logic                    r_twait;
    logic                    r_bwait;
    logic signed [24:0]      r_at;
    logic signed [24:0]      r_ab;
    logic [33:0]             r_wt;
    logic [33:0]             r_wb;
    logic signed [42:0]      r_pt_lo;
    logic signed [42:0]      r_pt_hi;
    logic signed [42:0]      r_pb_lo;
    logic signed [42:0]      r_pb_hi;
    logic signed [ACC_W-1:0] r_side_t;
    logic signed [ACC_W-1:0] r_side_b;
    logic                    r_out_valid;
    t_res                    r_out;

    logic out_free;
    assign out_free = !r_out_valid || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (!i_qstat.empty) n_state = B_PART;
            end
            B_PART: n_state = B_SUM;
            B_SUM:  n_state = B_DONE;
            B_DONE: begin
                if (out_free) n_state = B_IDLE;
            end
            default: n_state = B_IDLE;
        endcase
    end

    // queue read strobe
    always_comb begin
        unique case (r_state)
            B_IDLE:  o_pop = !i_qstat.empty;
            default: o_pop = 1'b0;
        endcase
    end

    // first products: sample by source code, global gain by fade weights
    logic [16:0]        gg;
    logic [16:0]        inv_fade;
    logic signed [24:0] at;
    logic signed [24:0] ab;

    always_comb begin
        gg       = (i_mix_gain > UNITY) ? UNITY : i_mix_gain;
        inv_fade = UNITY - i_job.fade;
        at       = i_job.s_top * $signed({1'b0, i_job.c_top});
        ab       = i_job.s_bot * $signed({1'b0, i_job.c_bot});
    end

    // rounding and saturation of the sum
    logic signed [ACC_W-1:0] acc;
    logic signed [19:0]      qw;
    logic signed [15:0]      mixed;

    always_comb begin
        acc = r_side_t + r_side_b + MIX_ROUND;
        qw  = acc[ACC_W-1:40];
        if (qw > 20'sd32767)       mixed = 16'sh7FFF;
        else if (qw < -20'sd32768) mixed = 16'sh8000;
        else                       mixed = qw[15:0];
    end

    // multiply chain and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_lane  <= i_job.lane;
                r_fade  <= i_job.fade;
                r_twait <= i_job.top_wait;
                r_bwait <= i_job.bot_wait;
                r_at    <= at;
                r_ab    <= ab;
                r_wt    <= gg * i_job.fade;
                r_wb    <= gg * inv_fade;
            end
            if (r_state == B_PART) begin
                r_pt_lo <= r_at * $signed({1'b0, r_wt[16:0]});
                r_pt_hi <= r_at * $signed({1'b0, r_wt[33:17]});
                r_pb_lo <= r_ab * $signed({1'b0, r_wb[16:0]});
                r_pb_hi <= r_ab * $signed({1'b0, r_wb[33:17]});
            end
            if (r_state == B_SUM) begin
                r_side_t <= (ACC_W'(r_pt_hi) <<< 17) + ACC_W'(r_pt_lo);
                r_side_b <= (ACC_W'(r_pb_hi) <<< 17) + ACC_W'(r_pb_lo);
            end
            if (r_state == B_DONE && out_free) begin
                r_out_valid    <= 1'b1;
                r_out.lane     <= r_lane;
                r_out.mixed    <= mixed;
                r_out.fade     <= r_fade;
                r_out.top_wait <= r_twait;
                r_out.bot_wait <= r_bwait;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

endmodule

>>> verif/rcf_mix_checker.sv
module rcf_mix_checker import rcf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    // target, lane, fade_cv, source_a .. source_g, zero fill
    input  logic [IN_W-1:0]  i_s_tdata,
    // op
    input  logic [1:0]       i_s_tuser,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // out_lane, mixed_sample, fade_level, zero fill
    input  logic [OUT_W-1:0] i_m_tdata,
    // top_waiting, bottom_waiting
    input  logic [1:0]       i_m_tuser,
    input  logic             i_cfg_valid,
    input  logic             i_cfg_ready,
    input  logic [1:0]       i_cfg_index,
    input  logic [55:0]      i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);

    // mirrored configuration
    t_range             range_sel;
    logic               instant_switch;
    logic [16:0]        master_gain;
    logic [GAINS_W-1:0] src_gain_codes;

    // mirrored routing state
    logic [2:0] sel_source;
    logic [2:0] top_src  [LANES];
    logic [2:0] bot_src  [LANES];
    logic [2:0] top_pend [LANES];
    logic [2:0] bot_pend [LANES];

    // mixes still owed by the block, oldest first
    t_res mix_due [$];

    // one line per mismatch, printing capped so a broken block stays readable
    task automatic report_mismatch(input string what, input longint got_v,
                                   input longint want_v);
        if (o_fail_count < 200)
            $display("rcf check: %s got %0d expected %0d", what, got_v, want_v);
        o_fail_count++;
    endtask

    // cv scaled into a Q1.16 fraction for the current range
    function automatic logic [16:0] fade_of(input logic signed [15:0] cv);
        int offs;
        int span;
        int x;
        case (range_sel)
            RANGE_UNI5:  begin offs = 0;     span = 10240; end
            RANGE_BI5:   begin offs = 10240; span = 20480; end
            RANGE_UNI10: begin offs = 0;     span = 20480; end
            default:     begin offs = 20480; span = 40960; end
        endcase
        x = int'(cv) + offs;
        if (x <= 0) return 17'd0;
        if (x >= span) return UNITY;
        return 17'((longint'(x) * 65536 + span / 2) / span);
    endfunction

    // one side: sample times source code times global gain, nothing for no source
    function automatic longint side_term(input logic [2:0] src,
                                         input logic [SRCS_W-1:0] smps,
                                         input longint gg);
        longint s;
        longint code;
        if (src >= NSRC) return 0;
        s    = longint'($signed(smps[src*SAMPLE_W +: SAMPLE_W]));
        code = longint'(src_gain_codes[src*8 +: 8]);
        return s * code * gg;
    endfunction

    // button press on a top or bottom route, all lanes for the none code
    task automatic arm_routes(input logic bottom_side, input logic [2:0] tgt);
        for (int l = 0; l < LANES; l++) begin
            if (tgt == NONE_SEL || tgt == 3'(l)) begin
                if (bottom_side) begin
                    if (bot_pend[l] == sel_source) bot_src[l] = sel_source;
                    bot_pend[l] = sel_source;
                end else begin
                    if (top_pend[l] == sel_source) top_src[l] = sel_source;
                    top_pend[l] = sel_source;
                end
            end
        end
    endtask

    // sample request: commit pending routes, mix, queue the expected result
    task automatic predict_mix(input logic [IN_W-1:0] d);
        logic [2:0]         ln;
        logic signed [15:0] cv;
        logic [16:0]        f;
        longint             gg;
        longint             acc;
        longint             q;
        t_res               r;
        ln = d[LANE_LSB +: 3];
        if (ln >= LANES) return;
        cv = d[CV_LSB +: 16];
        f  = fade_of(cv);
        if (instant_switch) begin
            top_src[ln] = top_pend[ln];
            bot_src[ln] = bot_pend[ln];
        end else begin
            if (f <= LOW_EDGE)  top_src[ln] = top_pend[ln];
            if (f >= HIGH_EDGE) bot_src[ln] = bot_pend[ln];
        end
        gg  = (master_gain > UNITY) ? longint'(UNITY) : longint'(master_gain);
        acc = side_term(top_src[ln], d[SRC_LSB +: SRCS_W], gg) * longint'(f)
            + side_term(bot_src[ln], d[SRC_LSB +: SRCS_W], gg) * (65536 - longint'(f));
        q = (acc + (longint'(1) <<< 39)) >>> 40;
        if (q > 32767)  q = 32767;
        if (q < -32768) q = -32768;
        r.lane     = ln;
        r.mixed    = 16'(q);
        r.fade     = f;
        r.top_wait = (top_src[ln] != top_pend[ln]);
        r.bot_wait = (bot_src[ln] != bot_pend[ln]);
        mix_due.push_back(r);
    endtask

    // watch all three channels at each rising edge
    always @(posedge i_clk) begin
        t_res got;
        t_res want;
        if (!i_rst_n) begin
            range_sel      = RANGE_UNI5;
            instant_switch = 1'b0;
            master_gain    = UNITY;
            src_gain_codes = '1;
            sel_source     = NONE_SEL;
            for (int l = 0; l < LANES; l++) begin
                top_src[l]  = 3'(l);
                top_pend[l] = 3'(l);
                bot_src[l]  = NONE_SEL;
                bot_pend[l] = NONE_SEL;
            end
            mix_due.delete();
        end else begin
            // register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_reg'(i_cfg_index))
                    REG_RANGE:  range_sel      = t_range'(i_cfg_data[1:0]);
                    REG_SWITCH: instant_switch = i_cfg_data[0];
                    REG_GGAIN:  master_gain    = i_cfg_data[16:0];
                    REG_SGAINS: src_gain_codes = i_cfg_data;
                endcase
            end
            // incoming requests
            if (i_s_tvalid && i_s_tready) begin
                case (t_op'(i_s_tuser))
                    OP_SAMPLE:  predict_mix(i_s_tdata);
                    OP_SELECT:  sel_source = i_s_tdata[TGT_LSB +: 3];
                    OP_SET_TOP: arm_routes(1'b0, i_s_tdata[TGT_LSB +: 3]);
                    OP_SET_BOT: arm_routes(1'b1, i_s_tdata[TGT_LSB +: 3]);
                endcase
            end
            // outgoing results against the oldest expectation
            if (i_m_tvalid && i_m_tready) begin
                got.lane     = i_m_tdata[2:0];
                got.mixed    = i_m_tdata[18:3];
                got.fade     = i_m_tdata[35:19];
                got.top_wait = i_m_tuser[0];
                got.bot_wait = i_m_tuser[1];
                if (mix_due.size() == 0) begin
                    report_mismatch("unexpected result, lane", got.lane, -1);
                end else begin
                    want = mix_due.pop_front();
                    if (got.lane != want.lane)
                        report_mismatch("out_lane", got.lane, want.lane);
                    if (got.mixed != want.mixed)
                        report_mismatch("mixed_sample", got.mixed, want.mixed);
                    if (got.fade != want.fade)
                        report_mismatch("fade_level", got.fade, want.fade);
                    if (got.top_wait != want.top_wait)
                        report_mismatch("top_waiting", got.top_wait, want.top_wait);
                    if (got.bot_wait != want.bot_wait)
                        report_mismatch("bottom_waiting", got.bot_wait, want.bot_wait);
                end
            end
        end
        o_pending = mix_due.size();
    end

endmodule

>>> verif/routed_crossfade_matrix_core_tb.sv
module routed_crossfade_matrix_core_tb;
    import rcf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              s_valid   = 1'b0;
    logic              s_ready;
    logic [IN_W-1:0]   s_data    = '0;
    logic [1:0]        s_user    = '0;
    logic              m_valid;
    logic              m_ready   = 1'b0;
    logic [OUT_W-1:0]  m_data;
    logic [1:0]        m_user;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [55:0]       cfg_data  = '0;

    int fail_count;
    int pending;
    int cycles = 0;
    bit gaps_on   = 1'b1;
    bit stalls_on = 1'b1;

    routed_crossfade_matrix_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .o_m_tuser   (m_user),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    rcf_mix_checker checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_valid),
        .i_s_tready   (s_ready),
        .i_s_tdata    (s_data),
        .i_s_tuser    (s_user),
        .i_m_tvalid   (m_valid),
        .i_m_tready   (m_ready),
        .i_m_tdata    (m_data),
        .i_m_tuser    (m_user),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk) begin
        m_ready <= !stalls_on || ($urandom_range(0, 99) >= 25);
    end

    // run guard
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("routed_crossfade_matrix_core_tb: done, errors");
            $finish;
        end
    end

    // sample value, extremes now and then
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [SRCS_W-1:0] rand_sources();
        logic [SRCS_W-1:0] v;
        for (int k = 0; k < NSRC; k++) v[k*SAMPLE_W +: SAMPLE_W] = pick_sample();
        return v;
    endfunction

    // fade cv, weighted towards the range edges and commit thresholds
    function automatic logic [15:0] pick_cv();
        int edge_pts [13] = '{-20481, -20480, -10240, 0, 1, 2, 3,
                              10238, 10239, 10240, 20478, 20479, 20480};
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 16'($urandom);
        if (r < 6) return 16'(int'($urandom_range(0, 49152)) - 24576);
        return 16'(edge_pts[$urandom_range(0, 12)] + int'($urandom_range(0, 4)) - 2);
    endfunction

    // one request on the input channel, starting and ending at a falling edge
    task automatic send_req(input t_op op, input logic [2:0] tgt, input logic [2:0] ln,
                            input logic [15:0] cv, input logic [SRCS_W-1:0] smps);
        if (gaps_on && $urandom_range(0, 99) < 25) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {{(IN_W - SRC_LSB - SRCS_W){1'b0}}, smps, cv, ln, tgt};
        do @(posedge clk); while (!s_ready);
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [2:0] ln, input logic [15:0] cv,
                               input logic [SRCS_W-1:0] smps);
        send_req(OP_SAMPLE, 3'($urandom), ln, cv, smps);
    endtask

    task automatic send_button(input t_op op, input logic [2:0] tgt);
        send_req(op, tgt, 3'($urandom), 16'($urandom), rand_sources());
    endtask

    // hold the input low until every mix is back, then let the block settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (24) @(negedge clk);
    endtask

    task automatic write_reg(input t_reg idx, input logic [55:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    // all four registers, unused upper data bits filled with noise
    task automatic set_config(input t_range rng, input logic sw, input logic [16:0] gg,
                              input logic [55:0] codes);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        write_reg(REG_RANGE, {junk[55:2], rng});
        junk = {$urandom, $urandom};
        write_reg(REG_SWITCH, {junk[55:1], sw});
        junk = {$urandom, $urandom};
        write_reg(REG_GGAIN, {junk[55:17], gg});
        write_reg(REG_SGAINS, codes);
        cfg_valid <= 1'b0;
    endtask

    // short hand-picked sequence on reset-like settings
    task automatic directed_run();
        send_sample(3'd0, 16'd0, {NSRC{16'h7fff}});
        send_sample(3'd1, 16'h7fff, {NSRC{16'h8000}});
        send_sample(3'd2, 16'h8000, rand_sources());
        // armed top route waits for the low extreme
        send_button(OP_SELECT, 3'd3);
        send_button(OP_SET_TOP, 3'd1);
        send_sample(3'd1, 16'd5120, rand_sources());
        send_sample(3'd1, 16'd0, rand_sources());
        // double press commits straight away
        send_button(OP_SELECT, 3'd5);
        send_button(OP_SET_BOT, 3'd2);
        send_button(OP_SET_BOT, 3'd2);
        send_sample(3'd2, 16'd5120, rand_sources());
        // bottom armed on all lanes, commits at the high extreme
        send_button(OP_SELECT, 3'd4);
        send_button(OP_SET_BOT, NONE_SEL);
        send_sample(3'd3, 16'd10240, rand_sources());
        send_sample(3'd5, 16'd10239, rand_sources());
        send_sample(3'd4, 16'd1, rand_sources());
        send_sample(3'd5, 16'd2, rand_sources());
        // no source routed to the top
        send_button(OP_SELECT, NONE_SEL);
        send_button(OP_SET_TOP, 3'd4);
        send_button(OP_SET_TOP, 3'd4);
        send_sample(3'd4, 16'd3000, rand_sources());
        // lane out of range gives nothing
        send_sample(3'd7, 16'd5000, rand_sources());
        send_button(OP_SELECT, 3'd6);
        send_button(OP_SET_TOP, NONE_SEL);
        send_sample(3'd6, 16'hffff, rand_sources());
    endtask

    // mostly select-then-arm sequences and samples, some stray presses
    task automatic random_run(input int n);
        int   k;
        int   r;
        t_op  side;
        logic [2:0] tgt;
        k = 0;
        while (k < n) begin
            r = $urandom_range(0, 99);
            if (r < 55) begin
                send_sample(($urandom_range(0, 99) < 3) ? 3'd7 : 3'($urandom_range(0, 6)),
                            pick_cv(), rand_sources());
                k++;
            end else if (r < 78) begin
                side = ($urandom_range(0, 1) == 0) ? OP_SET_TOP : OP_SET_BOT;
                tgt  = 3'($urandom_range(0, 7));
                send_button(OP_SELECT, 3'($urandom_range(0, 7)));
                send_button(side, tgt);
                k += 2;
                if ($urandom_range(0, 99) < 30) begin
                    send_button(side, tgt);
                    k++;
                end
            end else begin
                send_button(t_op'($urandom_range(1, 3)), 3'($urandom_range(0, 7)));
                k++;
            end
        end
    endtask

    // stimulus and verdict
    initial begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_config(RANGE_UNI5, 1'b0, UNITY, '1);
        directed_run();
        wait_idle();

        set_config(RANGE_BI5, 1'b0, 17'($urandom_range(0, 65536)), 56'({$urandom, $urandom}));
        random_run(300);
        wait_idle();

        // long stretch with no idling on either side
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        set_config(RANGE_BI10, 1'b1, 17'h1ffff, '0);
        random_run(300);
        wait_idle();
        gaps_on   = 1'b1;
        stalls_on = 1'b1;

        set_config(RANGE_UNI10, 1'b0, 17'd0, 56'({$urandom, $urandom}));
        random_run(300);
        wait_idle();

        // sender holds off mid-phase until the block has drained
        set_config(RANGE_BI10, 1'b0, UNITY, '1);
        random_run(150);
        wait_idle();
        random_run(150);
        wait_idle();

        set_config(RANGE_BI5, 1'b1, 17'($urandom), 56'({$urandom, $urandom}));
        random_run(300);
        wait_idle();

        set_config(RANGE_UNI5, 1'b1, 17'd32768, 56'({$urandom, $urandom}));
        random_run(300);
        wait_idle();

        if (fail_count == 0 && pending == 0) begin
            $display("routed_crossfade_matrix_core_tb: done, clean");
        end else begin
            $display("routed_crossfade_matrix_core_tb: done, errors");
        end
        $finish;
    end

endmodule
